@@ rtl/mdt_pkg.sv @@
`timescale 1ns / 1ps

package mdt_pkg;

   typedef enum logic [1:0] {
      ACT_CHECK   = 2'd0,
      ACT_SET_RSP = 2'd1,
      ACT_SWEEP   = 2'd2,
      ACT_FLUSH   = 2'd3
   } action_type;

   localparam int unsigned CSR_ADDR_W     = 3;
   localparam int unsigned CSR_DATA_W     = 32;
   localparam int unsigned CSR_WORD_W     = CSR_ADDR_W - 2;

   localparam logic [CSR_WORD_W-1:0] CSR_IDX_LIFETIME = '0;
   localparam logic [15:0]           LIFETIME_RESET   = 16'd247;

   localparam int unsigned REQ_DATA_W = 120;
   localparam int unsigned RSP_DATA_W = 72;

endpackage

@@ rtl/message_id_dedup_table.sv @@
`timescale 1ns / 1ps
// Check, set-response and sweep walk the whole table once through a single read port
// and then give the result beat.
// Flush rewrites every entry, one per cycle, before the result beat.
// One item at a time: the next beat is taken only once the result of the last is loaded
// into the output register; a stalled result beat holds the block back.
// Reset (synchronous, active high) clears the entry memory entry by entry; no item
// is taken during it, configuration writes are.

module message_id_dedup_table #(
   parameter int unsigned TABLE_DEPTH  = 32,
   parameter int unsigned SESSION_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // tdata, low bit up: message_id[15:0], session_id[7:0], now[31:0],
   // timeout_limit[31:0], response_handle[15:0], response_length[15:0]
   input  logic [mdt_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: action[1:0]
   input  logic [1:0]                          req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata, low bit up: is_duplicate, stored_handle[15:0], stored_length[15:0],
   // table_full, entry_found, next_timeout[31:0], zero fill
   output logic [mdt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mdt_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [mdt_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [mdt_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import mdt_pkg::*;

   localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned SESS_W = (SESSION_BITS < 8) ? SESSION_BITS : 8;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   typedef struct packed {
      logic              valid;
      logic [15:0]       mid;
      logic [SESS_W-1:0] sess;
      logic [31:0]       stamp;
      logic [15:0]       handle;
      logic [15:0]       length;
   } entry_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK,
      S_FINISH
   } state_type;

   // entry memory
   entry_type mem [TABLE_DEPTH];
   entry_type mem_q_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;

   state_type        state_ff, state_in;
   logic             flush_rsp_ff, flush_rsp_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             rd_run_ff, rd_run_in;
   logic             p1_vld_ff, p1_vld_in;
   logic [IDX_W-1:0] p1_idx_ff, p1_idx_in;
   logic             p2_vld_ff, p2_vld_in;
   logic [IDX_W-1:0] p2_idx_ff, p2_idx_in;
   entry_type        p2_ent_ff, p2_ent_in;
   logic [31:0]      age_ff, age_in;

   action_type       act_ff, act_in;
   logic [15:0]      mid_ff, mid_in;
   logic [SESS_W-1:0] sess_ff, sess_in;
   logic [31:0]      now_ff, now_in;
   logic [15:0]      rh_ff, rh_in;
   logic [15:0]      rl_ff, rl_in;

   logic             hit_ff, hit_in;
   logic [15:0]      sh_ff, sh_in;
   logic [15:0]      sl_ff, sl_in;
   logic             free_ok_ff, free_ok_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             found_ff, found_in;
   logic [31:0]      best_ff, best_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [15:0]      lifetime_ff, lifetime_in;

   logic             csr_wr;
   logic             match;
   logic             expired;
   logic [15:0]      left;
   logic             out_free;
   logic             is_check;
   logic             res_dup;
   logic             res_full;
   logic             res_found;
   logic [15:0]      res_sh;
   logic [15:0]      res_sl;
   logic [31:0]      res_nt;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      lifetime_in = lifetime_ff;
      if (csr_wr && csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_LIFETIME) begin
         lifetime_in = csr_pwdata[15:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_LIFETIME) begin
         csr_prdata = {16'b0, lifetime_ff};
      end
   end

   // stage-2 evaluation of one entry
   assign match   = p2_ent_ff.valid && p2_ent_ff.mid == mid_ff && p2_ent_ff.sess == sess_ff;
   assign expired = age_ff >= {16'b0, lifetime_ff};
   assign left    = lifetime_ff - age_ff[15:0];

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_check = act_ff == ACT_CHECK;

   always_comb begin
      res_dup   = 1'b0;
      res_full  = 1'b0;
      res_found = 1'b0;
      res_sh    = '0;
      res_sl    = '0;
      res_nt    = '0;
      case (act_ff)
         ACT_CHECK: begin
            res_dup  = hit_ff || !free_ok_ff;
            res_full = !hit_ff && !free_ok_ff;
            if (hit_ff) begin
               res_sh = sh_ff;
               res_sl = sl_ff;
            end
         end
         ACT_SET_RSP: begin
            res_found = found_ff;
         end
         ACT_SWEEP: begin
            res_nt = best_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      flush_rsp_in = flush_rsp_ff;
      ptr_in       = ptr_ff;
      rd_run_in    = 1'b0;
      p1_vld_in    = 1'b0;
      p1_idx_in    = ptr_ff;
      p2_vld_in    = p1_vld_ff;
      p2_idx_in    = p1_idx_ff;
      p2_ent_in    = mem_q_ff;
      age_in       = now_ff - mem_q_ff.stamp;
      act_in       = act_ff;
      mid_in       = mid_ff;
      sess_in      = sess_ff;
      now_in       = now_ff;
      rh_in        = rh_ff;
      rl_in        = rl_ff;
      hit_in       = hit_ff;
      sh_in        = sh_ff;
      sl_in        = sl_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff;
      mem_wdata    = '0;
      req_tready   = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            ptr_in    = ptr_ff + 1'b1;
            if (ptr_ff == LAST_IDX) begin
               ptr_in   = '0;
               state_in = flush_rsp_ff ? S_FINISH : S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               act_in      = action_type'(req_tuser);
               mid_in      = req_tdata[15:0];
               sess_in     = req_tdata[16 +: SESS_W];
               now_in      = req_tdata[55:24];
               best_in     = req_tdata[87:56];
               rh_in       = req_tdata[103:88];
               rl_in       = req_tdata[119:104];
               hit_in      = 1'b0;
               sh_in       = '0;
               sl_in       = '0;
               free_ok_in  = 1'b0;
               free_idx_in = '0;
               found_in    = 1'b0;
               ptr_in      = '0;
               if (action_type'(req_tuser) == ACT_FLUSH) begin
                  flush_rsp_in = 1'b1;
                  state_in     = S_CLEAR;
               end else begin
                  rd_run_in = 1'b1;
                  state_in  = S_WALK;
               end
            end
         end
         S_WALK: begin
            // issue reads ahead of the evaluation stage
            if (rd_run_ff) begin
               p1_vld_in = 1'b1;
               p1_idx_in = ptr_ff;
               ptr_in    = ptr_ff + 1'b1;
               rd_run_in = ptr_ff != LAST_IDX;
            end
            if (p2_vld_ff) begin
               mem_waddr = p2_idx_ff;
               case (act_ff)
                  ACT_CHECK: begin
                     if (match) begin
                        hit_in = 1'b1;
                        sh_in  = p2_ent_ff.handle;
                        sl_in  = p2_ent_ff.length;
                     end
                     if (!p2_ent_ff.valid && !free_ok_ff) begin
                        free_ok_in  = 1'b1;
                        free_idx_in = p2_idx_ff;
                     end
                  end
                  ACT_SET_RSP: begin
                     if (match) begin
                        found_in         = 1'b1;
                        mem_we           = 1'b1;
                        mem_wdata        = p2_ent_ff;
                        mem_wdata.handle = rh_ff;
                        mem_wdata.length = rl_ff;
                     end
                  end
                  ACT_SWEEP: begin
                     if (p2_ent_ff.valid) begin
                        if (expired) begin
                           // drop the stale entry
                           mem_we          = 1'b1;
                           mem_wdata       = p2_ent_ff;
                           mem_wdata.valid = 1'b0;
                        end else if ({16'b0, left} < best_ff) begin
                           best_in = {16'b0, left};
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               if (p2_idx_ff == LAST_IDX) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            // hold the result until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0, res_nt, res_found, res_full, res_sl, res_sh, res_dup};
               flush_rsp_in = 1'b0;
               state_in     = S_IDLE;
               if (is_check && !hit_ff && free_ok_ff) begin
                  mem_we           = 1'b1;
                  mem_waddr        = free_idx_ff;
                  mem_wdata.valid  = 1'b1;
                  mem_wdata.mid    = mid_ff;
                  mem_wdata.sess   = sess_ff;
                  mem_wdata.stamp  = now_ff;
                  mem_wdata.handle = '0;
                  mem_wdata.length = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         flush_rsp_ff <= 1'b0;
         ptr_ff       <= '0;
         rd_run_ff    <= 1'b0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lifetime_ff  <= LIFETIME_RESET;
      end else begin
         state_ff     <= state_in;
         flush_rsp_ff <= flush_rsp_in;
         ptr_ff       <= ptr_in;
         rd_run_ff    <= rd_run_in;
         p1_vld_ff    <= p1_vld_in;
         p2_vld_ff    <= p2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         lifetime_ff  <= lifetime_in;
      end
      p1_idx_ff   <= p1_idx_in;
      p2_idx_ff   <= p2_idx_in;
      p2_ent_ff   <= p2_ent_in;
      age_ff      <= age_in;
      act_ff      <= act_in;
      mid_ff      <= mid_in;
      sess_ff     <= sess_in;
      now_ff      <= now_in;
      rh_ff       <= rh_in;
      rl_ff       <= rl_in;
      hit_ff      <= hit_in;
      sh_ff       <= sh_in;
      sl_ff       <= sl_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      found_ff    <= found_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
